// ===== design/hex_pattern_gate_sequencer_assert.svh =====
// Assertion macros for the gate sequencer checker.
`ifndef HEX_PATTERN_GATE_SEQUENCER_ASSERT_SVH
`define HEX_PATTERN_GATE_SEQUENCER_ASSERT_SVH
// Implication checked on every clock, disabled in reset.
`define HPG_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: implication failed");
// Condition that must never hold, disabled in reset.
`define HPG_ASSERT_NEVER(label, clk, rstn, cond) \
  label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("%m: forbidden condition seen");
`endif

// ===== design/hpgs_pkg.sv =====
// Package: types and constants for the gate sequencer.
package hpgs_pkg;
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;
  localparam logic [1:0] REG_CLOCK_DELAY = 2'd0;
  localparam logic [1:0] REG_PULSE_TICKS = 2'd1;
  localparam logic [1:0] REG_POLY_SELECT = 2'd2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned STEP_W = 64;
  localparam int unsigned LEN_W = 5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_WALK,
    ST_PULSE,
    ST_OUT
  } state_e;
endpackage

// ===== design/hpgs_ram.sv =====
// Generic single port RAM with registered read.
module hpgs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== design/hex_pattern_gate_sequencer.sv =====
// Top level: 16-track gate sequencer with a pattern store held in RAM.
// Sequence: a write is taken in ST_IDLE, which it does not leave; a tick that fires a step
//   passes ST_READ (RAM read), ST_WALK (one track per cycle), ST_PULSE and ST_OUT.
// Throughput: one request at a time; a quiet tick goes straight to ST_PULSE and ST_OUT, and a
//   new request is accepted only back in ST_IDLE, after the result was taken with out_ready_i.
// Reset (rst_ni low, async): position, pattern, gates, pulses and edge history clear,
// pulse_ticks=480, poly_select=1; track lengths clear through per-entry valid bits.
module hex_pattern_gate_sequencer #(
  parameter int unsigned TRACKS = 16,
  parameter int unsigned PATTERNS = 16,
  parameter int unsigned MAX_NIBBLES = 16,
  parameter int unsigned POSITION_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [hpgs_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [hpgs_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         cmd_i,
  input  logic                         clock_level_i,
  input  logic                         reset_level_i,
  input  logic [15:0]                  pattern_gates_i,
  input  logic [3:0]                   pattern_index_i,
  input  logic                         select_connected_i,
  input  logic [3:0]                   track_index_i,
  input  logic [63:0]                  step_bits_i,
  input  logic [4:0]                   step_length_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [15:0]                  trigger_bits_o,
  output logic [15:0]                  gate_bits_o,
  output logic [15:0]                  clocked_gate_bits_o,
  output logic [15:0]                  inverse_trigger_bits_o,
  output logic [3:0]                   active_pattern_o
);
  import hpgs_pkg::*;

  localparam int unsigned TW = (TRACKS > 1) ? $clog2(TRACKS) : 1;
  localparam int unsigned PW = (PATTERNS > 1) ? $clog2(PATTERNS) : 1;
  localparam int unsigned DEPTH = PATTERNS * TRACKS;
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SLOTS = 2 * TRACKS;
  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned NW = (MAX_NIBBLES > 1) ? $clog2(MAX_NIBBLES) : 1;
  localparam logic [4:0] MAXLEN = 5'(MAX_NIBBLES);

  // Configuration registers.
  logic [3:0]  clock_delay_q;
  logic [15:0] pulse_ticks_q;
  logic        poly_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_delay_q <= '0;
      pulse_ticks_q <= 16'd480;
      poly_q        <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_CLOCK_DELAY: clock_delay_q <= cfg_wdata_i[3:0];
        REG_PULSE_TICKS: pulse_ticks_q <= cfg_wdata_i;
        REG_POLY_SELECT: poly_q        <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Control state.
  state_e state_q, state_d;
  logic [PW-1:0] pat_q, pat_d;
  logic [POSITION_WIDTH-1:0] pos_q, pos_d;
  logic pend_q, pend_d;
  logic [3:0] dcnt_q, dcnt_d;
  logic [TRACKS-1:0] gate_q, gate_d;
  logic [15:0] pulse_q [SLOTS];
  logic last_clk_q, last_rst_q;
  logic [15:0] last_gates_q, last_gates_d;
  logic [TW-1:0] trk_q;
  logic [TW-1:0] srv_q;
  logic clk_lvl_q;
  logic [DEPTH-1:0] valid_q;
  logic [TRACKS-1:0] trig_q, inv_q;
  logic rd_ok_q;
  // res_q[i] holds (position / 4) mod (i+1), one counter per possible length.
  logic [3:0] res_q [MAX_NIBBLES];

  // Stores: 64-bit steps (undefined until written) and lengths (valid-bit cleared).
  logic          wr_ok, ram_we;
  logic [AW-1:0] wr_addr, rd_addr, ram_addr;
  logic [63:0]   step_rd;
  logic [4:0]    len_rd, len_wr, len_eff;

  assign wr_ok = (32'(pattern_index_i) < PATTERNS) && (32'(track_index_i) < TRACKS);
  assign wr_addr = AW'(32'(pattern_index_i) * TRACKS + 32'(track_index_i));
  assign rd_addr = AW'(32'(pat_q) * TRACKS + 32'(trk_q));
  assign len_wr = (step_length_i > MAXLEN) ? MAXLEN : step_length_i;
  assign ram_we = in_valid_i && in_ready_o && (cmd_i == CMD_WRITE) && wr_ok;
  assign ram_addr = ram_we ? wr_addr : rd_addr;

  hpgs_ram #(.Width(STEP_W), .Depth(DEPTH)) u_step_ram (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(step_bits_i), .rdata_o(step_rd)
  );
  hpgs_ram #(.Width(LEN_W), .Depth(DEPTH)) u_len_ram (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(len_wr), .rdata_o(len_rd)
  );
  assign len_eff = rd_ok_q ? len_rd : '0;

  // Per-track step: position mod 4L = 4 * ((position / 4) mod L) + position[1:0].
  logic [NW-1:0] len_idx;
  logic [5:0] spos;
  logic step_bit;
  logic [SW-1:0] slot_trig, slot_inv;
  assign len_idx = NW'(len_eff - 5'd1);
  assign spos = {res_q[len_idx], pos_q[1:0]};
  assign step_bit = step_rd[6'd63 - spos];
  assign slot_trig = SW'(srv_q);
  assign slot_inv = SW'(TRACKS + 32'(srv_q));

  // Tick front end: reset edge, pattern select, clock edge.
  logic tick_acc, fire;
  logic [PW-1:0] pidx_sat;
  always_comb begin
    tick_acc = in_valid_i && in_ready_o && (cmd_i == CMD_TICK);
    pidx_sat = (32'(pattern_index_i) >= PATTERNS) ? PW'(PATTERNS - 1) : PW'(pattern_index_i);
    pat_d = pat_q;
    pos_d = pos_q;
    pend_d = pend_q;
    dcnt_d = dcnt_q;
    last_gates_d = last_gates_q;
    fire = 1'b0;
    if (reset_level_i && !last_rst_q) pos_d = '0;
    if (select_connected_i) begin
      if (poly_q) begin
        for (int k = 0; k < 16; k++) begin
          if (k < PATTERNS && pattern_gates_i[k] && !last_gates_q[k]) begin
            pat_d = PW'(k);
            pos_d = '0;
          end
        end
        last_gates_d = pattern_gates_i;
      end else if (pidx_sat != pat_q) begin
        pat_d = pidx_sat;
        pos_d = '0;
      end
    end
    if (clock_level_i && !last_clk_q) begin
      pend_d = 1'b1;
      dcnt_d = clock_delay_q;
    end
    if (pend_d) begin
      if (dcnt_d != 0) dcnt_d = dcnt_d - 4'd1;
      if (dcnt_d == 0) begin
        pend_d = 1'b0;
        fire = 1'b1;
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (tick_acc) state_d = fire ? ST_READ : ST_PULSE;
      ST_READ:  state_d = ST_WALK;
      ST_WALK:  if (32'(srv_q) == TRACKS - 1) state_d = ST_PULSE;
      ST_PULSE: state_d = ST_OUT;
      ST_OUT:   if (out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    out_valid_o = (state_q == ST_OUT);
    gate_d = gate_q;
    if (state_q == ST_WALK && len_eff != 0) gate_d[srv_q] = step_bit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pat_q <= '0;
      pos_q <= '0;
      pend_q <= 1'b0;
      dcnt_q <= '0;
      gate_q <= '0;
      last_clk_q <= 1'b0;
      last_rst_q <= 1'b0;
      last_gates_q <= '0;
      trk_q <= '0;
      srv_q <= '0;
      clk_lvl_q <= 1'b0;
      valid_q <= '0;
      trig_q <= '0;
      inv_q <= '0;
      rd_ok_q <= 1'b0;
      for (int i = 0; i < SLOTS; i++) pulse_q[i] <= '0;
      for (int i = 0; i < MAX_NIBBLES; i++) res_q[i] <= '0;
    end else begin
      state_q <= state_d;
      gate_q <= gate_d;
      rd_ok_q <= valid_q[rd_addr];
      // RAM data is registered, so srv_q follows trk_q to stay aligned with it.
      srv_q <= trk_q;
      if (ram_we) valid_q[wr_addr] <= 1'b1;
      if (tick_acc) begin
        pat_q <= pat_d;
        pos_q <= pos_d;
        pend_q <= pend_d;
        dcnt_q <= dcnt_d;
        last_gates_q <= last_gates_d;
        last_clk_q <= clock_level_i;
        last_rst_q <= reset_level_i;
        clk_lvl_q <= clock_level_i;
        trk_q <= '0;
        if (pos_d == '0) begin
          for (int i = 0; i < MAX_NIBBLES; i++) res_q[i] <= '0;
        end
      end
      if ((state_q == ST_READ || state_q == ST_WALK) && 32'(trk_q) != TRACKS - 1)
        trk_q <= trk_q + TW'(1);
      if (state_q == ST_WALK && 32'(srv_q) == TRACKS - 1) begin
        pos_q <= pos_q + POSITION_WIDTH'(1);
        if (&pos_q) begin
          for (int i = 0; i < MAX_NIBBLES; i++) res_q[i] <= '0;
        end else if (pos_q[1:0] == 2'b11) begin
          for (int i = 0; i < MAX_NIBBLES; i++)
            res_q[i] <= (32'(res_q[i]) == i) ? 4'd0 : res_q[i] + 4'd1;
        end
      end
      if (state_q == ST_WALK && len_eff != 0) begin
        if (step_bit) begin
          if (pulse_ticks_q > pulse_q[slot_trig]) pulse_q[slot_trig] <= pulse_ticks_q;
        end else begin
          if (pulse_ticks_q > pulse_q[slot_inv]) pulse_q[slot_inv] <= pulse_ticks_q;
        end
      end
      if (state_q == ST_PULSE) begin
        for (int t = 0; t < TRACKS; t++) begin
          trig_q[t] <= (pulse_q[t] != 0);
          inv_q[t]  <= (pulse_q[TRACKS + t] != 0);
          if (pulse_q[t] != 0) pulse_q[t] <= pulse_q[t] - 16'd1;
          if (pulse_q[TRACKS + t] != 0) pulse_q[TRACKS + t] <= pulse_q[TRACKS + t] - 16'd1;
        end
      end
    end
  end

  assign trigger_bits_o         = 16'(trig_q);
  assign inverse_trigger_bits_o = 16'(inv_q);
  assign gate_bits_o            = 16'(gate_q);
  assign clocked_gate_bits_o    = clk_lvl_q ? 16'(gate_q) : 16'd0;
  assign active_pattern_o       = 4'(pat_q);
endmodule

// ===== design/hpgs_checker.sv =====
// Port-level checker for the gate sequencer, bound to the top level.
`include "hex_pattern_gate_sequencer_assert.svh"
module hpgs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] gate_bits_o,
  input logic [15:0] clocked_gate_bits_o,
  input logic [3:0]  active_pattern_o
);
  `HPG_ASSERT_IMP(a_no_accept_while_out, clk_i, rst_ni, out_valid_o, !in_ready_o)
  `HPG_ASSERT_NEVER(a_clk_gate_subset, clk_i, rst_ni,
                    (clocked_gate_bits_o & ~gate_bits_o) != 16'd0)
  `HPG_ASSERT_IMP(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
                  ##1 (out_valid_o && $stable(active_pattern_o)))
endmodule

bind hex_pattern_gate_sequencer hpgs_checker u_hpgs_checker (
  .clk_i, .rst_ni, .in_ready_o, .out_valid_o, .out_ready_i,
  .gate_bits_o, .clocked_gate_bits_o, .active_pattern_o
);

// ===== tb/hex_pattern_gate_sequencer_test.sv =====
// Testbench for the gate sequencer: predicts each tick's outputs and checks them in order.
`timescale 1ns / 1ps
module hex_pattern_gate_sequencer_test;
  import hpgs_pkg::*;

  localparam int TRK = 16;
  localparam int PAT = 16;
  localparam int WATCHDOG = 20000;

  // One request as driven on the input channel.
  typedef struct packed {
    logic        cmd;
    logic        clk_lvl;
    logic        rst_lvl;
    logic [15:0] gates;
    logic [3:0]  pidx;
    logic        conn;
    logic [3:0]  track;
    logic [63:0] steps;
    logic [4:0]  len;
  } req_t;

  // One tick's outputs.
  typedef struct packed {
    logic [15:0] trig;
    logic [15:0] gate;
    logic [15:0] cgate;
    logic [15:0] inv;
    logic [3:0]  pat;
  } tick_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  req_t req_q = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [15:0] trigger_bits_o, gate_bits_o, clocked_gate_bits_o, inverse_trigger_bits_o;
  logic [3:0] active_pattern_o;

  always #5 clk_i = ~clk_i;

  hex_pattern_gate_sequencer u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o,
    .cmd_i(req_q.cmd), .clock_level_i(req_q.clk_lvl), .reset_level_i(req_q.rst_lvl),
    .pattern_gates_i(req_q.gates), .pattern_index_i(req_q.pidx),
    .select_connected_i(req_q.conn), .track_index_i(req_q.track),
    .step_bits_i(req_q.steps), .step_length_i(req_q.len),
    .out_valid_o, .out_ready_i,
    .trigger_bits_o, .gate_bits_o, .clocked_gate_bits_o, .inverse_trigger_bits_o,
    .active_pattern_o
  );

  // ---------------- sequencer predictor state ----------------
  logic [63:0] steps_mem [PAT][TRK];
  logic [4:0]  len_mem [PAT][TRK];
  logic [3:0]  cur_pat;
  logic [31:0] song_pos;
  logic        step_armed;
  logic [3:0]  step_wait;
  logic [15:0] gate_reg;
  logic [15:0] pulse_left [2*TRK];
  logic        prev_clk, prev_rst;
  logic [15:0] prev_gates;
  logic [3:0]  delay_cfg;
  logic [15:0] pulse_cfg;
  logic        poly_cfg;

  tick_out_t expected_ticks[$];
  req_t      pending_reqs[$];
  int        fail_cnt = 0;
  int        idle_in_pct = 25, idle_out_pct = 54;
  bit        hold_out = 0;
  int        hold_cnt = 0;
  int        stall_cnt = 0;
  bit        in_taken = 0;

  function automatic void add_req(req_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  function automatic void add_expected(tick_out_t o);
    expected_ticks.insert(expected_ticks.size(), o);
  endfunction

  function automatic void retrigger(int slot);
    if (pulse_cfg > pulse_left[slot]) pulse_left[slot] = pulse_cfg;
  endfunction

  // Fire one step on every nonempty track of the current pattern.
  function automatic void play_step();
    int unsigned nib, sp;
    for (int t = 0; t < TRK; t++) begin
      nib = 32'(len_mem[cur_pat][t]);
      if (nib != 0) begin
        sp = song_pos % (nib * 4);
        if (steps_mem[cur_pat][t][63 - sp]) begin
          gate_reg[t] = 1'b1;
          retrigger(t);
        end else begin
          gate_reg[t] = 1'b0;
          retrigger(TRK + t);
        end
      end
    end
    song_pos = song_pos + 32'd1;
  endfunction

  // Apply one accepted request; ticks queue their expected outputs.
  function automatic void predict_request(req_t r);
    tick_out_t o;
    logic [15:0] trig, inv;
    trig = '0;
    inv = '0;
    if (r.cmd == CMD_WRITE) begin
      steps_mem[r.pidx][r.track] = r.steps;
      len_mem[r.pidx][r.track] = (r.len > 5'd16) ? 5'd16 : r.len;
      return;
    end
    if (r.rst_lvl && !prev_rst) song_pos = '0;
    prev_rst = r.rst_lvl;
    if (r.conn) begin
      if (poly_cfg) begin
        for (int k = 0; k < PAT; k++)
          if (r.gates[k] && !prev_gates[k]) begin
            cur_pat = 4'(k);
            song_pos = '0;
          end
        prev_gates = r.gates;
      end else if (r.pidx != cur_pat) begin
        cur_pat = r.pidx;
        song_pos = '0;
      end
    end
    if (r.clk_lvl && !prev_clk) begin
      step_armed = 1'b1;
      step_wait = delay_cfg;
    end
    prev_clk = r.clk_lvl;
    if (step_armed) begin
      if (step_wait > 0) step_wait--;
      if (step_wait == 0) begin
        step_armed = 1'b0;
        play_step();
      end
    end
    for (int t = 0; t < TRK; t++) begin
      if (pulse_left[t] > 0) begin
        pulse_left[t]--;
        trig[t] = 1'b1;
      end
      if (pulse_left[TRK + t] > 0) begin
        pulse_left[TRK + t]--;
        inv[t] = 1'b1;
      end
    end
    o.trig = trig;
    o.gate = gate_reg;
    o.cgate = r.clk_lvl ? gate_reg : 16'h0;
    o.inv = inv;
    o.pat = cur_pat;
    add_expected(o);
  endfunction

  // ---------------- driver: falling edge ----------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        // previous request gone (or none); offer next one or idle
        if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_in_pct) begin
          req_q <= pending_reqs.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: random ready, or a counted hold-off.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_cnt > 0) begin
        out_ready_i <= 1'b0;
        hold_cnt <= hold_cnt - 1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= idle_out_pct);
      end
    end
  end

  // Acceptance is decided at the rising edge.
  // Because in_ready_o may change after the edge, track acceptance explicitly.
  always @(posedge clk_i) begin
    in_taken = rst_ni && in_valid_i && in_ready_o;
    if (in_taken) predict_request(req_q);
  end

  // ---------------- monitor: rising edge ----------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_ticks.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual pat=%0d gate=%h",
                 $time, active_pattern_o, gate_bits_o);
        fail_cnt++;
      end else begin
        tick_out_t e;
        e = expected_ticks.pop_front();
        if (trigger_bits_o !== e.trig) begin
          $display("%0t: trigger_bits expected %h actual %h", $time, e.trig, trigger_bits_o);
          fail_cnt++;
        end
        if (gate_bits_o !== e.gate) begin
          $display("%0t: gate_bits expected %h actual %h", $time, e.gate, gate_bits_o);
          fail_cnt++;
        end
        if (clocked_gate_bits_o !== e.cgate) begin
          $display("%0t: clocked_gate_bits expected %h actual %h", $time, e.cgate,
                   clocked_gate_bits_o);
          fail_cnt++;
        end
        if (inverse_trigger_bits_o !== e.inv) begin
          $display("%0t: inverse_trigger_bits expected %h actual %h", $time, e.inv,
                   inverse_trigger_bits_o);
          fail_cnt++;
        end
        if (active_pattern_o !== e.pat) begin
          $display("%0t: active_pattern expected %0d actual %0d", $time, e.pat,
                   active_pattern_o);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog: cycles with no handshake on either channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= WATCHDOG) begin
      $display("** hex_pattern_gate_sequencer: FAILED **");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  // Builds a write request; the tick fields are filled with noise. A never written entry
  // has length zero and so is never played.
  function automatic req_t make_write(logic [3:0] p, logic [3:0] t, logic [63:0] s,
                                      logic [4:0] n);
    req_t r;
    r = '0;
    r.cmd = CMD_WRITE;
    r.pidx = p;
    r.track = t;
    r.steps = s;
    r.len = n;
    r.gates = 16'($urandom);
    r.clk_lvl = 1'($urandom);
    r.rst_lvl = 1'($urandom);
    r.conn = 1'($urandom);
    return r;
  endfunction

  function automatic req_t make_tick(logic c, logic rs, logic [15:0] g, logic [3:0] p,
                                     logic cn);
    req_t r;
    r = '0;
    r.cmd = CMD_TICK;
    r.clk_lvl = c;
    r.rst_lvl = rs;
    r.gates = g;
    r.pidx = p;
    r.conn = cn;
    r.track = 4'($urandom);
    r.steps = {$urandom, $urandom};
    r.len = 5'($urandom);
    return r;
  endfunction

  task automatic cfg_write(logic [CFG_ADDR_W-1:0] a, logic [CFG_DATA_W-1:0] d);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= a;
    cfg_wdata_i <= d;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (a)
      REG_CLOCK_DELAY: delay_cfg = d[3:0];
      REG_PULSE_TICKS: pulse_cfg = d;
      REG_POLY_SELECT: poly_cfg = d[0];
      default: ;
    endcase
  endtask

  // Wait until every queued request went in and every tick came back, then settle.
  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid_i || expected_ticks.size() > 0)
      @(posedge clk_i);
    repeat (TRK + 8) @(posedge clk_i);
  endtask

  // Random phase: mostly clock trains over written patterns, some noise.
  task automatic random_burst(int n);
    logic c;
    c = 1'b0;
    for (int i = 0; i < n; i++) begin
      int sel;
      sel = $urandom_range(99);
      if (sel < 8) begin
        add_req(make_write(4'($urandom), 4'($urandom),
                           {$urandom, $urandom}, 5'($urandom_range(31))));
      end else begin
        logic [15:0] g;
        if (sel < 60) c = ~c;
        else if (sel < 75) c = 1'($urandom);
        g = ($urandom_range(3) == 0) ? 16'($urandom) : 16'(1 << $urandom_range(15));
        if ($urandom_range(2) == 0) g = '0;
        add_req(make_tick(c, $urandom_range(9) == 0, g, 4'($urandom),
                          $urandom_range(3) != 0));
      end
    end
  endtask

  initial begin
    for (int p = 0; p < PAT; p++)
      for (int t = 0; t < TRK; t++) begin
        steps_mem[p][t] = '0;
        len_mem[p][t] = '0;
      end
    for (int s = 0; s < 2*TRK; s++) pulse_left[s] = '0;
    cur_pat = '0;
    song_pos = '0;
    step_armed = 1'b0;
    step_wait = '0;
    gate_reg = '0;
    prev_clk = 1'b0;
    prev_rst = 1'b0;
    prev_gates = '0;
    delay_cfg = '0;
    pulse_cfg = 16'd480;
    poly_cfg = 1'b1;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: short pulses so they are visible, zero delay.
    cfg_write(REG_PULSE_TICKS, 16'd2);
    cfg_write(REG_CLOCK_DELAY, 16'd0);
    cfg_write(REG_POLY_SELECT, 16'd1);
    add_req(make_write(4'd0, 4'd0, 64'hA000_0000_0000_0000, 5'd1));
    add_req(make_write(4'd0, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 5'd16));
    add_req(make_write(4'd15, 4'd3, 64'h8000_0000_0000_0001, 5'd31));
    add_req(make_write(4'd15, 4'd4, 64'h0, 5'd0));
    for (int i = 0; i < 6; i++)
      add_req(make_tick(i[0], 1'b0, 16'h0, 4'd0, 1'b0));
    add_req(make_tick(1'b0, 1'b1, 16'h0, 4'd0, 1'b0));  // reset edge
    add_req(make_tick(1'b1, 1'b1, 16'h8001, 4'd0, 1'b1)); // highest wins
    add_req(make_tick(1'b0, 1'b0, 16'hFFFF, 4'd0, 1'b1));
    add_req(make_tick(1'b1, 1'b0, 16'h0001, 4'd0, 1'b1));
    add_req(make_tick(1'b1, 1'b0, 16'h0000, 4'd0, 1'b0));
    add_req(make_tick(1'b0, 1'b0, 16'h0000, 4'd15, 1'b1));
    drain();

    // Index mode, a nonzero clock delay, retriggering clock edges while pending.
    cfg_write(REG_POLY_SELECT, 16'd0);
    cfg_write(REG_CLOCK_DELAY, 16'd10);
    cfg_write(REG_PULSE_TICKS, 16'd1);
    for (int i = 0; i < 8; i++)
      add_req(make_tick(i[0], 1'b0, 16'h0, 4'd15, 1'b1));
    for (int i = 0; i < 24; i++)
      add_req(make_tick(1'b0, 1'b0, 16'h0, 4'd0, 1'b1));
    drain();

    // Random phases across settings and idling profiles.
    idle_in_pct = 25; idle_out_pct = 54;
    cfg_write(REG_CLOCK_DELAY, 16'd0);
    cfg_write(REG_PULSE_TICKS, 16'd3);
    cfg_write(REG_POLY_SELECT, 16'd1);
    for (int p = 0; p < PAT; p++)
      add_req(make_write(4'(p), 4'($urandom), {$urandom, $urandom},
                         5'($urandom_range(1, 16))));
    random_burst(400);
    // Receiver holds off a long while; sender keeps offering, block stalls input.
    wait (pending_reqs.size() < 350);
    hold_cnt = 300;
    drain();

    idle_in_pct = 54; idle_out_pct = 25;
    cfg_write(REG_POLY_SELECT, 16'd0);
    cfg_write(REG_CLOCK_DELAY, 16'd2);
    cfg_write(REG_PULSE_TICKS, 16'hFFFF);
    random_burst(450);
    drain();

    idle_in_pct = 0; idle_out_pct = 0;
    cfg_write(REG_POLY_SELECT, 16'd1);
    cfg_write(REG_CLOCK_DELAY, 16'd10);
    cfg_write(REG_PULSE_TICKS, 16'd1);
    random_burst(450);
    drain();

    cfg_write(REG_CLOCK_DELAY, 16'd1);
    cfg_write(REG_PULSE_TICKS, 16'd5);
    cfg_write(REG_POLY_SELECT, 16'd0);
    random_burst(500);
    drain();

    if (fail_cnt == 0)
      $display("** hex_pattern_gate_sequencer: PASSED **");
    else
      $display("** hex_pattern_gate_sequencer: FAILED **");
    $finish;
  end
endmodule
